FILE: rtl/jsv_pkg.sv
package jsv_pkg;

    // Field widths of the two streams
    localparam int SIZE_W = 9;
    localparam int STEP_W = 16;

    // tdata widths, rounded up to whole bytes
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 16;

    // Bit positions inside s_axis_tdata
    localparam int SIZE_LSB = 0;
    localparam int STEP_LSB = SIZE_LSB + SIZE_W;

    // Access control toward the alive-flag memory
    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic wr_data;
    } ram_ctl_t;

endpackage

FILE: rtl/jsv_alive_ram.sv
module jsv_alive_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic              aclk,
    input  jsv_pkg::ram_ctl_t ctl,
    input  logic [AW-1:0]     addr,
    output logic              rd_data
);
    import jsv_pkg::*;

    logic mem [DEPTH];
    logic rd_data_reg;

    // registered read, no reset on contents
    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[addr] <= ctl.wr_data;
        end
        if (ctl.rd_en) begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/jsv_rem_unit.sv
module jsv_rem_unit #(
    parameter int CW = 9
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [jsv_pkg::STEP_W-1:0] dividend,
    input  logic [CW-1:0]              divisor,
    output logic                       busy,
    output logic                       done,
    output logic [CW-1:0]              remainder
);
    import jsv_pkg::*;

    localparam int NW = $clog2(STEP_W + 1);

    logic [NW-1:0]     cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] quo_reg;
    logic [CW-1:0]     rem_reg;
    logic [CW-1:0]     div_reg;

    logic [CW:0]       trial;
    logic              fits;
    logic [CW-1:0]     rem_next;

    // restoring division, one dividend bit per cycle, MSB first
    always_comb begin
        trial    = {rem_reg, quo_reg[STEP_W-1]};
        fits     = (trial >= {1'b0, div_reg});
        rem_next = fits ? CW'(trial - {1'b0, div_reg}) : CW'(trial);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + NW'(1);
                if (cnt_reg == NW'(STEP_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= quo_reg << 1;
            rem_reg <= rem_next;
        end
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

FILE: rtl/josephus_survivor.sv
// Channel   Dir  tdata fields (LSB up)                 tuser
// s_axis    in   circle_size[8:0], step_count[24:9]     -
// m_axis    out  survivor[8:0]                         bad_size
//
// One transaction in, one transaction out. Per item: the alive memory is filled for
// m members, then for each removal the remainder unit gives the skip count and the
// ring is walked (about one lap at most), then a final scan finds the survivor. A zero
// circle size goes straight to the result. The single-port alive memory sets the walk.
// Reset: synchronous, active low; memory contents are never cleared.
// m_axis stall holds the result register; a new item is taken meanwhile.
module josephus_survivor #(
    parameter int MAX_MEMBERS = 256
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [jsv_pkg::S_TDATA_W-1:0] s_axis_tdata,  // circle_size, step_count
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [jsv_pkg::M_TDATA_W-1:0] m_axis_tdata,  // survivor
    output logic                          m_axis_tuser   // bad_size
);
    import jsv_pkg::*;

    localparam int AW = $clog2(MAX_MEMBERS);
    localparam int CW = $clog2(MAX_MEMBERS + 1);
    localparam logic [31:0] MAX_U = MAX_MEMBERS;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_INIT     = 4'd1;
    localparam logic [3:0] ST_MOD_GO   = 4'd2;
    localparam logic [3:0] ST_MOD_WAIT = 4'd3;
    localparam logic [3:0] ST_RD       = 4'd4;
    localparam logic [3:0] ST_EV       = 4'd5;
    localparam logic [3:0] ST_SCAN_RD  = 4'd6;
    localparam logic [3:0] ST_SCAN_EV  = 4'd7;
    localparam logic [3:0] ST_DONE     = 4'd8;

    logic [3:0]        state_reg, state_next;
    logic [CW-1:0]     m_reg, m_next;        // saturated circle size
    logic [STEP_W-1:0] step_reg, step_next;  // n-1 with n=0 taken as 1
    logic [CW-1:0]     left_reg, left_next;  // members still alive
    logic [CW-1:0]     pass_reg, pass_next;  // living members still to skip
    logic [AW-1:0]     pos_reg, pos_next;
    logic              bad_reg, bad_next;
    logic [SIZE_W-1:0] surv_reg, surv_next;

    logic              out_valid_reg, out_valid_next;
    logic [SIZE_W-1:0] out_surv_reg, out_surv_next;
    logic              out_bad_reg, out_bad_next;

    logic [SIZE_W-1:0] in_size;
    logic [STEP_W-1:0] in_step;
    logic [31:0]       size_sat;
    logic [CW-1:0]     pos_plus;
    logic [AW-1:0]     pos_ring;
    logic              load_out;

    ram_ctl_t          ram_ctl;
    logic              ram_rdata;
    logic              rem_start;
    logic              rem_busy;
    logic              rem_done;
    logic [CW-1:0]     rem_value;

    jsv_alive_ram #(
        .DEPTH (MAX_MEMBERS),
        .AW    (AW)
    ) u_ram (
        .aclk    (aclk),
        .ctl     (ram_ctl),
        .addr    (pos_reg),
        .rd_data (ram_rdata)
    );

    jsv_rem_unit #(
        .CW (CW)
    ) u_rem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (rem_start),
        .dividend  (step_reg),
        .divisor   (left_reg),
        .busy      (rem_busy),
        .done      (rem_done),
        .remainder (rem_value)
    );

    assign in_size  = s_axis_tdata[SIZE_LSB +: SIZE_W];
    assign in_step  = s_axis_tdata[STEP_LSB +: STEP_W];
    assign size_sat = (32'(in_size) > MAX_U) ? MAX_U : 32'(in_size);

    // ring advance, wrapping at the circle size
    assign pos_plus = CW'(pos_reg) + CW'(1);
    assign pos_ring = (pos_plus >= m_reg) ? '0 : AW'(pos_plus);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign load_out      = (state_reg == ST_DONE) && (!out_valid_reg || m_axis_tready);

    always_comb begin
        state_next      = state_reg;
        m_next          = m_reg;
        step_next       = step_reg;
        left_next       = left_reg;
        pass_next       = pass_reg;
        pos_next        = pos_reg;
        bad_next        = bad_reg;
        surv_next       = surv_reg;
        ram_ctl.wr_en   = 1'b0;
        ram_ctl.rd_en   = 1'b0;
        ram_ctl.wr_data = 1'b0;
        rem_start       = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    if (in_size == '0) begin
                        bad_next   = 1'b1;
                        surv_next  = '0;
                        state_next = ST_DONE;
                    end else begin
                        bad_next   = 1'b0;
                        m_next     = CW'(size_sat);
                        left_next  = CW'(size_sat);
                        step_next  = (in_step == '0) ? '0 : in_step - STEP_W'(1);
                        pos_next   = '0;
                        state_next = ST_INIT;
                    end
                end
            end
            ST_INIT: begin
                // mark members 0..m-1 alive, one per cycle
                ram_ctl.wr_en   = 1'b1;
                ram_ctl.wr_data = 1'b1;
                if (pos_plus == m_reg) begin
                    pos_next   = '0;
                    state_next = (m_reg == CW'(1)) ? ST_SCAN_RD : ST_MOD_GO;
                end else begin
                    pos_next = AW'(pos_plus);
                end
            end
            ST_MOD_GO: begin
                rem_start  = 1'b1;
                state_next = ST_MOD_WAIT;
            end
            ST_MOD_WAIT: begin
                if (rem_done) begin
                    pass_next  = rem_value;
                    state_next = ST_RD;
                end
            end
            ST_RD: begin
                ram_ctl.rd_en = 1'b1;
                state_next    = ST_EV;
            end
            ST_EV: begin
                // the removal write and the next read never share a cycle
                if (ram_rdata) begin
                    if (pass_reg == '0) begin
                        ram_ctl.wr_en   = 1'b1;
                        ram_ctl.wr_data = 1'b0;
                        left_next       = left_reg - CW'(1);
                        if (left_reg == CW'(2)) begin
                            pos_next   = '0;
                            state_next = ST_SCAN_RD;
                        end else begin
                            state_next = ST_MOD_GO;
                        end
                    end else begin
                        pass_next  = pass_reg - CW'(1);
                        pos_next   = pos_ring;
                        state_next = ST_RD;
                    end
                end else begin
                    pos_next   = pos_ring;
                    state_next = ST_RD;
                end
            end
            ST_SCAN_RD: begin
                ram_ctl.rd_en = 1'b1;
                state_next    = ST_SCAN_EV;
            end
            ST_SCAN_EV: begin
                if (ram_rdata) begin
                    surv_next  = SIZE_W'(pos_plus);
                    state_next = ST_DONE;
                end else begin
                    pos_next   = pos_ring;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_DONE: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register: holds under stall
    always_comb begin
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_surv_next  = out_surv_reg;
        out_bad_next   = out_bad_reg;
        if (load_out) begin
            out_valid_next = 1'b1;
            out_surv_next  = surv_reg;
            out_bad_next   = bad_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_reg        <= m_next;
        step_reg     <= step_next;
        left_reg     <= left_next;
        pass_reg     <= pass_next;
        pos_reg      <= pos_next;
        bad_reg      <= bad_next;
        surv_reg     <= surv_next;
        out_surv_reg <= out_surv_next;
        out_bad_reg  <= out_bad_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = M_TDATA_W'(out_surv_reg);
    assign m_axis_tuser  = out_bad_reg;

    // walk only runs with two or more alive and a skip count below that
    a_walk_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EV) |-> (left_reg >= CW'(2) && pass_reg < left_reg))
        else $error("walk counters out of range");

    a_pos_in_ring: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RD || state_reg == ST_EV || state_reg == ST_SCAN_RD ||
         state_reg == ST_SCAN_EV) |-> (CW'(pos_reg) < m_reg))
        else $error("ring position beyond circle size");

    a_rem_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MOD_GO) |-> !rem_busy)
        else $error("remainder unit restarted while busy");

    a_ram_port: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_ctl.wr_en && ram_ctl.rd_en))
        else $error("memory read and write in one cycle");

    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result register loaded outside the done state");

endmodule
